>>> src/fptc_pkg.sv
package fptc_pkg;

  // Geometry
  localparam int BANK_ENTRIES = 2048;
  localparam int LANES        = 4;
  localparam int SLOT_CNT     = 8;

  localparam int AW        = $clog2(BANK_ENTRIES);      // entry index within a bank
  localparam int IDX_W     = AW + 1;                    // write index, may run past the bank
  localparam int CNT_W     = IDX_W - 2;                 // per-slot entry count
  localparam int MEM_AW    = AW + 1;                    // bank bit plus entry index
  localparam int MEM_DEPTH = 2 ** MEM_AW;

  // Port field widths
  localparam int REQ_TYPE_W  = 2;
  localparam int SLOT_W      = 3;
  localparam int CHAR_W      = 8;
  localparam int RD_ADDR_W   = 11;
  localparam int DATA_W      = 8;
  localparam int FLAG_W      = 7;
  localparam int LOAD_POS_W  = 12;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_START  = 2'd0,
    REQ_CHAR   = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_READ   = 2'd3
  } req_type_e;

  // Pattern text characters
  localparam logic [CHAR_W-1:0] CH_END   = 8'h24;  // '$'
  localparam logic [CHAR_W-1:0] CH_NOT   = 8'h21;  // '!'
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;  // '?'
  localparam logic [CHAR_W-1:0] CH_R_LO  = 8'h72;
  localparam logic [CHAR_W-1:0] CH_R_UP  = 8'h52;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;

  // Flag codes
  localparam logic [FLAG_W-1:0] FLG_NONE     = 7'h00;
  localparam logic [FLAG_W-1:0] FLG_EMPTY    = 7'h01;  // what an unloaded entry reads as
  localparam logic [FLAG_W-1:0] FLG_END      = 7'h02;
  localparam logic [FLAG_W-1:0] FLG_NOT      = 7'h05;
  localparam logic [FLAG_W-1:0] FLG_WILD_ANY = 7'h11;
  localparam logic [FLAG_W-1:0] FLG_WILD_R   = 7'h09;
  localparam logic [FLAG_W-1:0] FLG_WILD_X   = 7'h01;
  localparam logic [FLAG_W-1:0] FLG_RPT_MASK = 7'h60;
  localparam logic [FLAG_W-1:0] FLG_RPT_ONE  = 7'h20;
  localparam logic [FLAG_W-1:0] FLG_RPT_TWO  = 7'h40;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [SLOT_W-1:0]     slot;
    logic [CHAR_W-1:0]     char_byte;
    logic                  read_bank;
    logic [RD_ADDR_W-1:0]  read_address;
  } req_t;

  typedef struct packed {
    logic              data_we;
    logic [MEM_AW-1:0] data_addr;
    logic [DATA_W-1:0] data;
    logic              flag_we;
    logic [MEM_AW-1:0] flag_addr;
    logic [FLAG_W-1:0] flags;
  } mem_wr_t;

  typedef struct packed {
    logic              re;
    logic [MEM_AW-1:0] addr;
    logic              is_read;
    logic              hit;
  } mem_rd_t;

  typedef struct packed {
    logic [IDX_W-1:0] load_position;
    logic             stopped;
  } load_status_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h37);
    end
    return r;
  endfunction

endpackage

>>> src/fptc_req_if.sv
interface fptc_req_if import fptc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [SLOT_W-1:0]     slot;
  logic [CHAR_W-1:0]     char_byte;
  logic                  read_bank;
  logic [RD_ADDR_W-1:0]  read_address;

  modport source (
    output valid, req_type, slot, char_byte, read_bank, read_address,
    input  ready
  );

  modport sink (
    input  valid, req_type, slot, char_byte, read_bank, read_address,
    output ready
  );
endinterface

>>> src/fptc_rsp_if.sv
interface fptc_rsp_if import fptc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DATA_W-1:0]     entry_data;
  logic [FLAG_W-1:0]     entry_flags;
  logic [LOAD_POS_W-1:0] load_position;
  logic                  load_stopped;

  modport source (
    output valid, entry_data, entry_flags, load_position, load_stopped,
    input  ready
  );

  modport sink (
    input  valid, entry_data, entry_flags, load_position, load_stopped,
    output ready
  );
endinterface

>>> src/fptc_ram.sv
module fptc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/fptc_engine.sv
module fptc_engine import fptc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  req_t         req_i,
  output mem_wr_t      wr_o,
  output mem_rd_t      rd_o,
  output load_status_t status_o
);

  logic [SLOT_W-1:0] active_q, active_d;
  logic [IDX_W-1:0]  wi_q, wi_d;
  logic              pend_v_q, pend_v_d;
  logic [3:0]        pend_q, pend_d;
  logic              skip_q, skip_d;
  logic              stopped_q, stopped_d;
  logic [FLAG_W-1:0] pf_q, pf_d;
  logic [CNT_W-1:0]  cnt_q [SLOT_CNT];
  logic [CNT_W-1:0]  cnt_d [SLOT_CNT];

  logic              has_prev;
  logic [IDX_W-1:0]  wi_adv;
  logic [IDX_W-1:0]  prev_idx;
  logic              bank;
  hex_t              hx;
  logic              adv;
  logic [DATA_W-1:0] adv_data;
  logic [FLAG_W-1:0] adv_flags;
  logic              modify;
  logic [FLAG_W-1:0] mod_flags;
  logic              stop_now;
  logic [AW-1:0]     rd_idx;
  logic [SLOT_W-1:0] rd_slot;

  assign has_prev = wi_q >= IDX_W'(LANES);
  assign wi_adv   = wi_q + IDX_W'(LANES);
  assign prev_idx = wi_q - IDX_W'(LANES);
  assign bank     = active_q[SLOT_W-1];
  assign hx       = hex_decode(req_i.char_byte);
  assign rd_idx   = AW'(req_i.read_address);
  assign rd_slot  = {req_i.read_bank, req_i.read_address[1:0]};

  always_comb begin
    active_d  = active_q;
    wi_d      = wi_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    skip_d    = skip_q;
    stopped_d = stopped_q;
    pf_d      = pf_q;
    cnt_d     = cnt_q;
    wr_o      = '0;
    rd_o      = '0;
    adv       = 1'b0;
    adv_data  = '0;
    adv_flags = FLG_NONE;
    modify    = 1'b0;
    mod_flags = pf_q;
    stop_now  = 1'b0;

    if (fire_i) begin
      unique case (req_type_e'(req_i.req_type))
        REQ_START: begin
          active_d            = req_i.slot;
          cnt_d[req_i.slot]   = '0;
          wi_d                = IDX_W'(req_i.slot[1:0]);
          pend_v_d            = 1'b0;
          skip_d              = 1'b0;
          stopped_d           = 1'b0;
          pf_d                = FLG_NONE;
        end
        REQ_CHAR: begin
          if (!stopped_q && wi_q < IDX_W'(BANK_ENTRIES)) begin
            if (skip_q) begin
              skip_d = 1'b0;
            end else begin
              case (req_i.char_byte) inside
                CH_END: begin
                  // no entry yet: the end mark becomes the first entry
                  if (!has_prev) begin
                    adv       = 1'b1;
                    adv_flags = FLG_END;
                  end else begin
                    modify    = 1'b1;
                    mod_flags = pf_q | FLG_END;
                  end
                  stop_now = 1'b1;
                end
                CH_NOT: begin
                  if (has_prev) begin
                    modify    = 1'b1;
                    mod_flags = pf_q | FLG_NOT;
                  end
                end
                CH_PLUS: begin
                  // repeat counter saturates at two
                  if (has_prev) begin
                    modify = 1'b1;
                    if ((pf_q & FLG_RPT_MASK) == FLG_RPT_ONE) begin
                      mod_flags = (pf_q | FLG_RPT_TWO) & ~FLG_RPT_ONE;
                    end else if ((pf_q & FLG_RPT_MASK) == FLG_NONE) begin
                      mod_flags = pf_q | FLG_RPT_ONE;
                    end
                  end
                end
                CH_QUEST: begin
                  adv       = 1'b1;
                  adv_flags = FLG_WILD_ANY;
                  skip_d    = 1'b1;
                end
                CH_R_LO, CH_R_UP: begin
                  adv       = 1'b1;
                  adv_flags = FLG_WILD_R;
                  skip_d    = 1'b1;
                end
                CH_X_LO, CH_X_UP: begin
                  adv       = 1'b1;
                  adv_flags = FLG_WILD_X;
                  skip_d    = 1'b1;
                end
                default: begin
                  if (hx.ok) begin
                    if (pend_v_q) begin
                      adv      = 1'b1;
                      adv_data = {pend_q, hx.val};
                      pend_v_d = 1'b0;
                    end else begin
                      pend_v_d = 1'b1;
                      pend_d   = hx.val;
                    end
                  end
                end
              endcase
            end
          end
        end
        REQ_FINISH: begin
          cnt_d[active_q] = wi_q[IDX_W-1:2];
        end
        REQ_READ: begin
          rd_o.re      = 1'b1;
          rd_o.is_read = 1'b1;
          rd_o.addr    = {req_i.read_bank, rd_idx};
          rd_o.hit     = (32'(req_i.read_address) < 32'(BANK_ENTRIES)) &&
                         (32'(req_i.read_address[RD_ADDR_W-1:2]) < 32'(cnt_q[rd_slot]));
        end
      endcase
    end

    // new entry at the write index
    if (adv) begin
      wr_o.data_we   = 1'b1;
      wr_o.data_addr = {bank, wi_q[AW-1:0]};
      wr_o.data      = adv_data;
      wr_o.flag_we   = 1'b1;
      wr_o.flag_addr = {bank, wi_q[AW-1:0]};
      wr_o.flags     = adv_flags;
      pf_d           = adv_flags;
      wi_d           = wi_adv;
      if (wi_adv >= IDX_W'(BANK_ENTRIES)) begin
        stopped_d = 1'b1;
      end
    end

    // flag rewrite of the previous entry; never in the same cycle as adv
    if (modify) begin
      wr_o.flag_we   = 1'b1;
      wr_o.flag_addr = {bank, prev_idx[AW-1:0]};
      wr_o.flags     = mod_flags;
      pf_d           = mod_flags;
    end

    if (stop_now) begin
      stopped_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      wi_q      <= '0;
      pend_v_q  <= 1'b0;
      pend_q    <= '0;
      skip_q    <= 1'b0;
      stopped_q <= 1'b1;
      pf_q      <= FLG_NONE;
      for (int i = 0; i < SLOT_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      active_q  <= active_d;
      wi_q      <= wi_d;
      pend_v_q  <= pend_v_d;
      pend_q    <= pend_d;
      skip_q    <= skip_d;
      stopped_q <= stopped_d;
      pf_q      <= pf_d;
      cnt_q     <= cnt_d;
    end
  end

  assign status_o.load_position = wi_q;
  assign status_o.stopped       = stopped_q;

  a_data_with_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.data_we |-> wr_o.flag_we && (wr_o.flag_addr == wr_o.data_addr))
    else $error("data write without matching flag write");

  a_open_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stopped_q |-> wi_q < IDX_W'(BANK_ENTRIES))
    else $error("open load past the bank end");

  a_skip_has_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> wi_q >= IDX_W'(LANES))
    else $error("skip pending with no wildcard entry behind it");

  a_start_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (req_i.req_type == REQ_START) |=>
      !stopped_q && (wi_q[1:0] == $past(req_i.slot[1:0])) && !skip_q)
    else $error("start did not open the load on the slot lane");

endmodule

>>> src/frame_pattern_text_compiler.sv
// Frame pattern text compiler.
// req_i carries one word per request: start a load of a slot, one pattern
// text character, finish the open load, or read one compiled entry. rsp_o
// returns exactly one word per request, in order: the entry data and flags
// for a read (data 0 and flags 1 past the slot's loaded count, both 0 for
// other requests), plus the write position and stop flag after the request.
// A request passes one input register, then the compile step with the
// registered read of the data and flag memories, before rsp_o.valid rises.
// Throughput is one word per cycle; a word is accepted even while a finished
// response waits on a stalled receiver, and a stall of two words deep holds
// req_i.ready low until rsp_o.ready returns.
// Reset clears the per-slot counts (all patterns empty) and leaves the load
// closed. The entry memories are not cleared; entries past a slot's count
// never reach the output. Removing a pattern is a start followed by a finish.
module frame_pattern_text_compiler import fptc_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  fptc_req_if.sink    req_i,
  fptc_rsp_if.source  rsp_o
);

  logic         a_v_q, a_v_d;
  req_t         a_q, a_d;
  logic         b_v_q, b_v_d;
  logic         b_rd_q, b_rd_d;
  logic         b_hit_q, b_hit_d;
  logic         b_free;
  logic         fire;
  logic         in_acc;
  mem_wr_t      wr;
  mem_rd_t      rd;
  load_status_t status;
  logic [DATA_W-1:0] data_rdata;
  logic [FLAG_W-1:0] flag_rdata;

  assign b_free      = !b_v_q || rsp_o.ready;
  assign fire        = a_v_q && b_free;
  assign req_i.ready = !a_v_q || b_free;
  assign in_acc      = req_i.valid && req_i.ready;

  assign a_d = '{
    req_type:     req_i.req_type,
    slot:         req_i.slot,
    char_byte:    req_i.char_byte,
    read_bank:    req_i.read_bank,
    read_address: req_i.read_address
  };

  always_comb begin
    a_v_d   = a_v_q;
    b_v_d   = b_v_q;
    b_rd_d  = b_rd_q;
    b_hit_d = b_hit_q;
    if (in_acc) begin
      a_v_d = 1'b1;
    end else if (fire) begin
      a_v_d = 1'b0;
    end
    if (fire) begin
      b_v_d   = 1'b1;
      b_rd_d  = rd.is_read;
      b_hit_d = rd.hit;
    end else if (rsp_o.ready) begin
      b_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      a_v_q <= a_v_d;
      b_v_q <= b_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q <= a_d;
    end
    b_rd_q  <= b_rd_d;
    b_hit_q <= b_hit_d;
  end

  fptc_engine u_engine (
    .clk_i,
    .rst_ni,
    .fire_i   (fire),
    .req_i    (a_q),
    .wr_o     (wr),
    .rd_o     (rd),
    .status_o (status)
  );

  fptc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_data_ram (
    .clk_i,
    .we_i    (wr.data_we),
    .waddr_i (wr.data_addr),
    .wdata_i (wr.data),
    .re_i    (rd.re),
    .raddr_i (rd.addr),
    .rdata_o (data_rdata)
  );

  fptc_ram #(
    .WIDTH (FLAG_W),
    .DEPTH (MEM_DEPTH)
  ) u_flag_ram (
    .clk_i,
    .we_i    (wr.flag_we),
    .waddr_i (wr.flag_addr),
    .wdata_i (wr.flags),
    .re_i    (rd.re),
    .raddr_i (rd.addr),
    .rdata_o (flag_rdata)
  );

  // load state only moves when a word enters the output stage, so it lines
  // up with the word held there
  assign rsp_o.valid         = b_v_q;
  assign rsp_o.entry_data    = (b_rd_q && b_hit_q) ? data_rdata : '0;
  assign rsp_o.entry_flags   = !b_rd_q ? FLG_NONE : (b_hit_q ? flag_rdata : FLG_EMPTY);
  assign rsp_o.load_position = LOAD_POS_W'(status.load_position);
  assign rsp_o.load_stopped  = status.stopped;

endmodule

>>> tb/frame_pattern_text_compiler_checker.sv
module frame_pattern_text_compiler_checker import fptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fptc_req_if         req_i,
  fptc_rsp_if         rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned words_due_o
);

  typedef struct packed {
    logic [DATA_W-1:0]     data;
    logic [FLAG_W-1:0]     flags;
    logic [LOAD_POS_W-1:0] position;
    logic                  stopped;
  } rsp_word_t;

  rsp_word_t         words_due_q [$];
  int unsigned       mismatches;
  int unsigned       words_checked;

  // Shadow of the compiled pattern memories and the load state
  logic [DATA_W-1:0] byte_mem [MEM_DEPTH];
  logic [FLAG_W-1:0] flag_mem [MEM_DEPTH];
  logic [CNT_W-1:0]  slot_count [SLOT_CNT];
  logic [SLOT_W-1:0] load_slot;
  logic [IDX_W-1:0]  wr_idx;
  logic [4:0]        held_nibble;  // 5'h10: no nibble held
  logic              skip_byte;
  logic              load_done;
  logic [FLAG_W-1:0] last_flags;   // flags of the entry at wr_idx - LANES

  assign mismatch_count_o = mismatches;

  task automatic report_error(input string msg);
    $display("%0t: ERROR word %0d: %s", $time, words_checked, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic store_entry(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data,
                             input logic [FLAG_W-1:0] flags);
    if (idx < BANK_ENTRIES) begin
      byte_mem[{load_slot[2], idx[AW-1:0]}] = data;
      flag_mem[{load_slot[2], idx[AW-1:0]}] = flags;
    end
  endtask

  // Modifiers rewrite the flags of the entry just behind the write position
  task automatic restore_previous();
    logic [IDX_W-1:0] prev;
    if (wr_idx >= LANES) begin
      prev = wr_idx - IDX_W'(LANES);
      flag_mem[{load_slot[2], prev[AW-1:0]}] = last_flags;
    end
  endtask

  task automatic step_position(input logic [FLAG_W-1:0] flags);
    last_flags = flags;
    wr_idx = wr_idx + IDX_W'(LANES);
    if (wr_idx >= BANK_ENTRIES) load_done = 1'b1;
  endtask

  task automatic compile_char(input logic [CHAR_W-1:0] c);
    logic [4:0]        digit;
    logic [FLAG_W-1:0] wild;
    if (load_done || wr_idx >= BANK_ENTRIES) return;
    store_entry(wr_idx, '0, FLG_NONE);
    if (skip_byte) begin
      skip_byte = 1'b0;
      return;
    end
    digit = 5'h10;
    if (c >= "0" && c <= "9") digit = 5'(c - "0");
    else if (c >= "a" && c <= "f") digit = 5'(c - "a" + 10);
    else if (c >= "A" && c <= "F") digit = 5'(c - "A" + 10);
    case (c)
      CH_END: begin
        if (wr_idx < LANES) begin
          store_entry(wr_idx, '0, FLG_END);
          step_position(FLG_END);
        end else begin
          last_flags |= FLG_END;
          restore_previous();
        end
        load_done = 1'b1;
      end
      CH_NOT: begin
        if (wr_idx >= LANES) begin
          last_flags |= FLG_NOT;
          restore_previous();
        end
      end
      CH_PLUS: begin
        if (wr_idx >= LANES) begin
          if ((last_flags & FLG_RPT_MASK) == FLG_RPT_ONE)
            last_flags = (last_flags | FLG_RPT_TWO) & ~FLG_RPT_ONE;
          else if ((last_flags & FLG_RPT_MASK) == FLG_NONE)
            last_flags |= FLG_RPT_ONE;
          restore_previous();
        end
      end
      CH_QUEST, CH_R_LO, CH_R_UP, CH_X_LO, CH_X_UP: begin
        wild = (c == CH_QUEST) ? FLG_WILD_ANY :
               (c == CH_R_LO || c == CH_R_UP) ? FLG_WILD_R : FLG_WILD_X;
        skip_byte = 1'b1;
        store_entry(wr_idx, '0, wild);
        step_position(wild);
      end
      default: begin
        if (!digit[4]) begin
          if (!held_nibble[4]) begin
            store_entry(wr_idx, {held_nibble[3:0], digit[3:0]}, FLG_NONE);
            held_nibble = 5'h10;
            step_position(FLG_NONE);
          end else begin
            held_nibble = digit;
          end
        end
      end
    endcase
  endtask

  task automatic compile_request(input req_t rq, output rsp_word_t w);
    logic [SLOT_W-1:0] rd_slot;
    w = '0;
    case (req_type_e'(rq.req_type))
      REQ_START: begin
        load_slot           = rq.slot;
        slot_count[rq.slot] = '0;
        wr_idx              = IDX_W'(rq.slot[1:0]);
        held_nibble         = 5'h10;
        skip_byte           = 1'b0;
        load_done           = 1'b0;
        last_flags          = FLG_NONE;
      end
      REQ_CHAR:   compile_char(rq.char_byte);
      REQ_FINISH: slot_count[load_slot] = wr_idx[IDX_W-1:2];
      default: begin
        rd_slot = {rq.read_bank, rq.read_address[1:0]};
        w.flags = FLG_EMPTY;
        if (CNT_W'(rq.read_address[RD_ADDR_W-1:2]) < slot_count[rd_slot]) begin
          w.data  = byte_mem[{rq.read_bank, rq.read_address}];
          w.flags = flag_mem[{rq.read_bank, rq.read_address}];
        end
      end
    endcase
    w.position = LOAD_POS_W'(wr_idx);
    w.stopped  = load_done;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rsp_word_t got;
    rsp_word_t want;
    req_t      rq;
    if (!rst_ni) begin
      words_due_q.delete();
      mismatches    = 0;
      words_checked = 0;
      foreach (slot_count[i]) slot_count[i] = '0;
      load_slot   = '0;
      wr_idx      = '0;
      held_nibble = 5'h10;
      skip_byte   = 1'b0;
      load_done   = 1'b1;
      last_flags  = FLG_NONE;
      words_due_o <= 0;
    end else begin
      // results first: a word accepted now cannot answer a request of this edge
      if (rsp_i.valid && rsp_i.ready) begin
        got = '{data: rsp_i.entry_data, flags: rsp_i.entry_flags,
                position: rsp_i.load_position, stopped: rsp_i.load_stopped};
        if (words_due_q.size() == 0) begin
          report_error("result word with nothing expected");
        end else begin
          want = words_due_q.pop_front();
          check_field("entry_data", 16'(got.data), 16'(want.data));
          check_field("entry_flags", 16'(got.flags), 16'(want.flags));
          check_field("load_position", 16'(got.position), 16'(want.position));
          check_field("load_stopped", 16'(got.stopped), 16'(want.stopped));
        end
        words_checked++;
      end
      if (req_i.valid && req_i.ready) begin
        rq = '{req_type: req_i.req_type, slot: req_i.slot, char_byte: req_i.char_byte,
               read_bank: req_i.read_bank, read_address: req_i.read_address};
        compile_request(rq, want);
        words_due_q.push_back(want);
      end
      words_due_o <= words_due_q.size();
    end
  end

endmodule

>>> tb/frame_pattern_text_compiler_test.sv
module frame_pattern_text_compiler_test;
  import fptc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned words_due;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          stalls_asked = 0;
  int          useful_words = 0;

  fptc_req_if req_if ();
  fptc_rsp_if rsp_if ();

  frame_pattern_text_compiler DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  frame_pattern_text_compiler_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .mismatch_count_o (mismatch_count),
    .words_due_o      (words_due)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin : sink_side
    int stalls_done;
    int stall_left;
    stalls_done = 0;
    stall_left  = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (stalls_done != stalls_asked) begin
        stalls_done++;
        stall_left = 300;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_word(input req_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= w.req_type;
    req_if.slot         <= w.slot;
    req_if.char_byte    <= w.char_byte;
    req_if.read_bank    <= w.read_bank;
    req_if.read_address <= w.read_address;
    do @(posedge clk_i); while (!req_if.ready);
    useful_words++;
  endtask

  // Fields a request does not use carry random values
  function automatic req_t noise_word(input req_type_e kind);
    req_t w;
    w.req_type = kind;
    {w.slot, w.char_byte, w.read_bank, w.read_address} = 23'($urandom);
    return w;
  endfunction

  task automatic send_start(input logic [SLOT_W-1:0] s);
    req_t w;
    w      = noise_word(REQ_START);
    w.slot = s;
    send_word(w);
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] c);
    req_t w;
    w           = noise_word(REQ_CHAR);
    w.char_byte = c;
    send_word(w);
  endtask

  task automatic send_finish();
    send_word(noise_word(REQ_FINISH));
  endtask

  task automatic send_read(input logic b, input logic [RD_ADDR_W-1:0] a);
    req_t w;
    w              = noise_word(REQ_READ);
    w.read_bank    = b;
    w.read_address = a;
    send_word(w);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (words_due != 0);
  endtask

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] wildcard_char();
    case ($urandom_range(4))
      0:       return CH_QUEST;
      1:       return CH_R_LO;
      2:       return CH_R_UP;
      3:       return CH_X_LO;
      default: return CH_X_UP;
    endcase
  endfunction

  // One load of a random slot with well-formed text and some noise mixed in
  task automatic load_random_pattern(input int budget);
    logic [SLOT_W-1:0] s;
    logic [CHAR_W-1:0] v;
    int                made;
    int                pick;
    s    = SLOT_W'($urandom_range(SLOT_CNT - 1));
    made = 0;
    send_start(s);
    while (made < budget) begin
      pick = $urandom_range(99);
      v    = CHAR_W'($urandom);
      if (pick < 50) begin
        send_char(hex_char(v[7:4]));
        send_char(hex_char(v[3:0]));
        made++;
      end else if (pick < 64) begin
        send_char(wildcard_char());
        send_char(v);  // skipped byte, may be anything
        made++;
      end else if (pick < 72) begin
        send_char(CH_NOT);
      end else if (pick < 82) begin
        send_char(CH_PLUS);
      end else if (pick < 88) begin
        send_char((v == CH_END) ? 8'hFF : v);
      end else if (pick < 92) begin
        send_char(hex_char(v[3:0]));  // lone nibble shifts the pairing
      end else begin
        send_read(s[2], RD_ADDR_W'(s[1:0]) + RD_ADDR_W'(4 * $urandom_range(made)));
      end
    end
    if ($urandom_range(3) != 0) begin
      send_char(CH_END);
      if ($urandom_range(4) == 0) begin
        send_char(CHAR_W'($urandom));
        useful_words--;  // ignored once stopped
      end
    end
    if ($urandom_range(9) != 0) send_finish();
    if ($urandom_range(7) == 0) send_finish();
    repeat ($urandom_range(1, 5))
      send_read(s[2], RD_ADDR_W'(s[1:0]) + RD_ADDR_W'(4 * $urandom_range(budget + 1)));
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int words,
                           input bit pressure);
    int stop_at;
    int pick;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at       = useful_words + words;
    if (pressure) begin
      // long receiver stall while a load runs into the end of the bank
      stalls_asked <= stalls_asked + 1;
      load_random_pattern(530);
    end
    while (useful_words < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        load_random_pattern(($urandom_range(99) < 85) ? $urandom_range(12) :
                                                        $urandom_range(40));
      end else if (pick < 78) begin
        send_start(SLOT_W'($urandom));  // removal: start then finish
        send_finish();
      end else if (pick < 85) begin
        send_finish();
      end else begin
        repeat ($urandom_range(1, 4)) send_read(1'($urandom), RD_ADDR_W'($urandom));
      end
    end
    drain_results();
  endtask

  initial begin
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= REQ_START;
    req_if.slot         <= '0;
    req_if.char_byte    <= '0;
    req_if.read_bank    <= 1'b0;
    req_if.read_address <= '0;
    src_idle_pct  = 6;
    sink_idle_pct = 64;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // finish right after reset writes count 0 to slot 0
    send_finish();
    send_read(1'b0, '0);
    send_start(3'd7);
    send_char(CH_NOT);  // modifiers with no entry behind them
    send_char(CH_PLUS);
    send_char("f");
    send_char("F");
    send_char(CH_QUEST);
    send_char(8'hFF);
    send_char(CH_R_UP);
    send_char(8'h00);
    send_char(CH_X_LO);
    send_char(CH_END);  // skipped, not an end marker
    send_char(CH_PLUS);
    send_char(CH_PLUS);
    send_char(CH_PLUS);  // counter saturates
    send_char(CH_NOT);
    send_char(8'h80);
    send_char(CH_END);
    send_finish();
    send_read(1'b1, 11'd3);
    send_read(1'b1, 11'd15);
    // end marker with no entry yet
    send_start(3'd0);
    send_char(CH_END);
    send_finish();
    send_read(1'b0, 11'd0);
    drain_results();

    run_phase(6, 64, 130, 1'b0);
    run_phase(64, 6, 130, 1'b0);
    run_phase(0, 0, 1300, 1'b1);

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && words_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
